/* src/nlr_pkg.sv */
// Package: shared types and constants for the numeric literal recognizer.
`default_nettype none
package nlr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int LIMIT_W     = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd38;

  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_OTHER = 3'd0;
  localparam logic [CLS_W-1:0] CLS_DIGIT = 3'd1;
  localparam logic [CLS_W-1:0] CLS_BLANK = 3'd2;
  localparam logic [CLS_W-1:0] CLS_SIGN  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_POINT = 3'd4;
  localparam logic [CLS_W-1:0] CLS_EXP   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_END   = 3'd6;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [3:0]       digit;
  } nlr_tok_t;

endpackage
`default_nettype wire

/* src/nlr_front.sv */
// Front end: accepts characters and classifies them into tokens for the queue.
`default_nettype none
module nlr_front
  import nlr_pkg::*;
(
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic     in_tlast,     // end_of_string
  input  wire logic     q_full,
  output logic          q_push,
  output nlr_tok_t      q_tok
);

  logic [3:0] dig_off;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign dig_off   = in_tdata[3:0];

  always_comb begin
    q_tok.digit = dig_off;
    if (in_tlast) begin
      q_tok.cls = CLS_END;
    end else if (in_tdata >= 8'h30 && in_tdata <= 8'h39) begin
      q_tok.cls = CLS_DIGIT;
    end else if (in_tdata == 8'h20 || in_tdata == 8'h09 || in_tdata == 8'h0A) begin
      q_tok.cls = CLS_BLANK;
    end else if (in_tdata == 8'h2B || in_tdata == 8'h2D) begin
      q_tok.cls = CLS_SIGN;
    end else if (in_tdata == 8'h2E) begin
      q_tok.cls = CLS_POINT;
    end else if (in_tdata == 8'h65 || in_tdata == 8'h45) begin
      q_tok.cls = CLS_EXP;
    end else begin
      q_tok.cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

/* src/nlr_queue.sv */
// Token queue between the classifier and the scanner.
`default_nettype none
module nlr_queue
  import nlr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire nlr_tok_t push_tok,
  output logic          full,
  input  wire logic     pop,
  output logic          q_valid,
  output nlr_tok_t      q_tok
);

  nlr_tok_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule
`default_nettype wire

/* src/nlr_back.sv */
// Back end: grammar scanner over tokens and the registered verdict output.
`default_nettype none
module nlr_back
  import nlr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire nlr_tok_t           q_tok,
  output logic                    q_pop,
  input  wire logic [LIMIT_W-1:0] max_exp,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic                    out_is_number
);

  localparam logic [3:0] PH_LEAD    = 4'd0;
  localparam logic [3:0] PH_SIGN    = 4'd1;
  localparam logic [3:0] PH_INT     = 4'd2;
  localparam logic [3:0] PH_POINT   = 4'd3;
  localparam logic [3:0] PH_FRAC    = 4'd4;
  localparam logic [3:0] PH_EXPE    = 4'd5;
  localparam logic [3:0] PH_EXPSIGN = 4'd6;
  localparam logic [3:0] PH_EXPDIG  = 4'd7;
  localparam logic [3:0] PH_TRAIL   = 4'd8;
  localparam logic [3:0] PH_REJECT  = 4'd9;
  localparam logic [3:0] PH_DONE    = 4'd10;

  logic [3:0]         ph_r, ph_nxt;
  logic [LIMIT_W-1:0] icnt_r, icnt_nxt;
  logic               pt_r, pt_nxt;
  logic               frac_r, frac_nxt;
  logic [1:0]         ecnt_r, ecnt_nxt;
  logic [6:0]         eval_r, eval_nxt;
  logic               ovld_r, ovld_nxt;
  logic               onum_r, onum_nxt;

  logic       is_digit, is_blank, is_sign, is_point, is_exp, is_end;
  logic [3:0] trail_ph, mant_ph, leave_ph;
  logic       mant_ok;
  logic       do_end;
  logic [6:0] eval_mac;

  assign is_digit = (q_tok.cls == CLS_DIGIT);
  assign is_blank = (q_tok.cls == CLS_BLANK);
  assign is_sign  = (q_tok.cls == CLS_SIGN);
  assign is_point = (q_tok.cls == CLS_POINT);
  assign is_exp   = (q_tok.cls == CLS_EXP);
  assign is_end   = (q_tok.cls == CLS_END);

  assign q_pop  = q_valid && (!is_end || !ovld_r || out_tready);
  assign do_end = q_pop && is_end;

  assign eval_mac = (eval_r << 3) + (eval_r << 1) + {3'd0, q_tok.digit};

  always_comb begin
    trail_ph = is_blank ? PH_TRAIL : (is_end ? PH_DONE : PH_REJECT);
    mant_ok  = (icnt_r != '0) || (pt_r && frac_r);
    mant_ph  = !mant_ok ? PH_REJECT : (is_exp ? PH_EXPE : trail_ph);
    if (icnt_r >= max_exp) begin
      leave_ph = PH_REJECT;
    end else if (is_point) begin
      leave_ph = PH_POINT;
    end else begin
      leave_ph = mant_ph;
    end
  end

  always_comb begin
    ph_nxt   = ph_r;
    icnt_nxt = icnt_r;
    pt_nxt   = pt_r;
    frac_nxt = frac_r;
    ecnt_nxt = ecnt_r;
    eval_nxt = eval_r;
    unique case (ph_r)
      PH_LEAD, PH_SIGN: begin
        if (ph_r == PH_LEAD && is_blank) begin
          ph_nxt = PH_LEAD;
        end else if (ph_r == PH_LEAD && is_end) begin
          ph_nxt = PH_REJECT;
        end else if (ph_r == PH_LEAD && is_sign) begin
          ph_nxt = PH_SIGN;
        end else if (is_digit) begin
          icnt_nxt = LIMIT_W'(1);
          ph_nxt   = PH_INT;
        end else if (is_point) begin
          ph_nxt = leave_ph;
          pt_nxt = (leave_ph == PH_POINT) ? 1'b1 : pt_r;
        end else begin
          ph_nxt = PH_REJECT;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          if (icnt_r != '1) begin
            icnt_nxt = icnt_r + 1'b1;
          end
        end else begin
          ph_nxt = leave_ph;
          pt_nxt = (leave_ph == PH_POINT) ? 1'b1 : pt_r;
        end
      end
      PH_POINT, PH_FRAC: begin
        if (is_digit) begin
          frac_nxt = 1'b1;
          ph_nxt   = PH_FRAC;
        end else begin
          ph_nxt = mant_ph;
        end
      end
      PH_EXPE, PH_EXPSIGN: begin
        if (ph_r == PH_EXPE && is_sign) begin
          ph_nxt = PH_EXPSIGN;
        end else if (is_digit) begin
          ecnt_nxt = 2'd1;
          eval_nxt = {3'd0, q_tok.digit};
          ph_nxt   = PH_EXPDIG;
        end else begin
          ph_nxt = PH_REJECT;
        end
      end
      PH_EXPDIG: begin
        if (is_digit) begin
          if (ecnt_r < 2'd2) begin
            eval_nxt = eval_mac;
            ecnt_nxt = ecnt_r + 1'b1;
          end else begin
            ecnt_nxt = 2'd3;
          end
        end else if (ecnt_r == 2'd3 ||
                     (ecnt_r == 2'd2 && eval_r >= {1'b0, max_exp})) begin
          ph_nxt = PH_REJECT;
        end else begin
          ph_nxt = trail_ph;
        end
      end
      PH_TRAIL: begin
        ph_nxt = trail_ph;
      end
      default: begin
        ph_nxt = ph_r;
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    onum_nxt = onum_r;
    if (do_end) begin
      ovld_nxt = 1'b1;
      onum_nxt = (ph_nxt == PH_DONE);
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || do_end) begin
      ph_r   <= PH_LEAD;
      icnt_r <= '0;
      pt_r   <= 1'b0;
      frac_r <= 1'b0;
      ecnt_r <= '0;
      eval_r <= '0;
    end else if (q_pop) begin
      ph_r   <= ph_nxt;
      icnt_r <= icnt_nxt;
      pt_r   <= pt_nxt;
      frac_r <= frac_nxt;
      ecnt_r <= ecnt_nxt;
      eval_r <= eval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    onum_r <= onum_nxt;
  end

  assign out_tvalid    = ovld_r;
  assign out_is_number = onum_r;

endmodule
`default_nettype wire

/* src/numeric_literal_recognizer_unit.sv */
// Top level: streaming decimal number recognizer.
// The input stream carries one character per word in in_tdata; a word with
// in_tlast high ends the string, and its character is ignored. For each such
// word one verdict word appears on the output stream, with out_tdata bit 0
// set when the whole string was a valid decimal number.
// The limit on integer digit count and two-digit exponent value is written
// through cfg_wen and cfg_wdata; the user must write it only while the block
// is idle, and the block itself does not enforce this. It resets to 38. The
// ending word's verdict passes through the queue and the out_tvalid register.
// Throughput is one word per cycle while no ending token waits on a stalled
// output: the classifier feeds a four-word queue and the scanner takes one
// token per cycle from it. Only the ending token waits on the output register,
// which frees in the cycle it is taken. When the receiver stalls, the verdict
// holds, the queue fills, and in_tready falls once four words are waiting.
// Reset empties the queue, drops out_tvalid, returns the scanner to the
// leading blank phase and restores the limit.
`default_nettype none
module numeric_literal_recognizer_unit
  import nlr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] ch
  input  wire logic               in_tlast,   // end_of_string
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // [0] is_number, [7:1] zero
  input  wire logic               cfg_wen,
  input  wire logic [LIMIT_W-1:0] cfg_wdata   // max_exponent
);

  logic [LIMIT_W-1:0] max_exp_r;
  logic               q_full, q_push, q_pop, q_valid;
  nlr_tok_t           push_tok, q_tok;
  logic               is_number;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_exp_r <= LIMIT_RESET;
    end else if (cfg_wen) begin
      max_exp_r <= cfg_wdata;
    end
  end

  nlr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok)
  );

  nlr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  nlr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_tok         (q_tok),
    .q_pop         (q_pop),
    .max_exp       (max_exp_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_is_number (is_number)
  );

  assign out_tdata = {7'd0, is_number};

  a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("scanner popped an empty queue");

  a_end_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_tok.cls == CLS_END) |=> out_tvalid)
    else $error("ending word produced no verdict");

  a_stall_means_queued: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the streaming numeric literal recognizer.
module tb_top;
  import nlr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 10;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_POINT = 8'h2E;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_E_UP  = 8'h45;
  localparam logic [7:0] CHR_E_LO  = 8'h65;
  localparam logic [8:0] SYM_END   = 9'h100;

  typedef enum logic [3:0] {
    P_LEAD, P_SIGN, P_INT, P_POINT, P_FRAC, P_EXP_MARK, P_EXP_SIGN,
    P_EXP_DIGITS, P_TRAIL, P_BAD, P_DONE
  } scan_phase_e;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_wen = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  scan_phase_e sc_phase = P_LEAD;
  logic [5:0] sc_int_cnt = '0;
  logic sc_point = 1'b0;
  logic sc_frac = 1'b0;
  logic [1:0] sc_exp_cnt = '0;
  logic [6:0] sc_exp_val = '0;
  logic [LIMIT_W-1:0] sc_limit = LIMIT_RESET;

  logic verdicts_due[$];
  logic [7:0] cand[$];

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int cycles = 0;
  int fail_count = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int verdicts_seen = 0;
  int valid_seen = 0;

  numeric_literal_recognizer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] ch
    .in_tlast   (in_tlast),   // end_of_string
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] is_number, [7:1] zero
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)   // max_exponent
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d verdicts pending", cycles,
               verdicts_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic is_digit(input logic [8:0] s);
    return s >= CHR_ZERO && s <= CHR_NINE;
  endfunction

  function automatic logic is_blank(input logic [8:0] s);
    return s == CHR_SPACE || s == CHR_TAB || s == CHR_LF;
  endfunction

  function automatic logic is_sign(input logic [8:0] s);
    return s == CHR_PLUS || s == CHR_MINUS;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 30) begin
      $display("MISMATCH at cycle %0d: %s", cycles, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_seen++;
      if (out_tdata[0]) begin
        valid_seen++;
      end
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none pending", out_tdata[0]));
      end else begin
        if (out_tdata[0] !== verdicts_due[0]) begin
          report_mismatch($sformatf("is_number %b, predicted %b", out_tdata[0],
                                    verdicts_due[0]));
        end
        if (out_tdata[7:1] !== 7'd0) begin
          report_mismatch($sformatf("pad bits %b not zero", out_tdata[7:1]));
        end
        void'(verdicts_due.pop_front());
      end
    end
  end

  task automatic clear_scan();
    sc_phase = P_LEAD;
    sc_int_cnt = '0;
    sc_point = 1'b0;
    sc_frac = 1'b0;
    sc_exp_cnt = '0;
    sc_exp_val = '0;
  endtask

  task automatic close_trail(input logic [8:0] s);
    if (is_blank(s)) sc_phase = P_TRAIL;
    else if (s == SYM_END) sc_phase = P_DONE;
    else sc_phase = P_BAD;
  endtask

  task automatic close_mantissa(input logic [8:0] s);
    if (!(sc_int_cnt != 0 || (sc_point && sc_frac))) sc_phase = P_BAD;
    else if (s == CHR_E_LO || s == CHR_E_UP) sc_phase = P_EXP_MARK;
    else close_trail(s);
  endtask

  task automatic leave_integer(input logic [8:0] s);
    if (sc_int_cnt >= sc_limit) begin
      sc_phase = P_BAD;
    end else if (s == CHR_POINT) begin
      sc_point = 1'b1;
      sc_phase = P_POINT;
    end else begin
      close_mantissa(s);
    end
  endtask

  task automatic begin_mantissa(input logic [8:0] s);
    if (is_digit(s)) begin
      sc_int_cnt = 6'd1;
      sc_phase = P_INT;
    end else if (s == CHR_POINT) begin
      leave_integer(s);
    end else begin
      sc_phase = P_BAD;
    end
  endtask

  task automatic begin_exponent(input logic [8:0] s);
    if (is_digit(s)) begin
      sc_exp_cnt = 2'd1;
      sc_exp_val = 7'(s - CHR_ZERO);
      sc_phase = P_EXP_DIGITS;
    end else begin
      sc_phase = P_BAD;
    end
  endtask

  // One symbol of the scanner; SYM_END stands for the end-of-string word.
  task automatic scan_symbol(input logic [8:0] s);
    int acc;
    case (sc_phase)
      P_LEAD: begin
        if (is_blank(s)) sc_phase = P_LEAD;
        else if (s == SYM_END) sc_phase = P_BAD;
        else if (is_sign(s)) sc_phase = P_SIGN;
        else begin_mantissa(s);
      end
      P_SIGN: begin_mantissa(s);
      P_INT: begin
        if (is_digit(s)) begin
          if (sc_int_cnt != 6'd63) sc_int_cnt = sc_int_cnt + 6'd1;
        end else begin
          leave_integer(s);
        end
      end
      P_POINT, P_FRAC: begin
        if (is_digit(s)) begin
          sc_frac = 1'b1;
          sc_phase = P_FRAC;
        end else begin
          close_mantissa(s);
        end
      end
      P_EXP_MARK: begin
        if (is_sign(s)) sc_phase = P_EXP_SIGN;
        else begin_exponent(s);
      end
      P_EXP_SIGN: begin_exponent(s);
      P_EXP_DIGITS: begin
        if (is_digit(s)) begin
          if (sc_exp_cnt < 2'd2) begin
            acc = int'(sc_exp_val) * 10 + int'(s) - int'(CHR_ZERO);
            sc_exp_val = acc[6:0];
            sc_exp_cnt = sc_exp_cnt + 2'd1;
          end else begin
            sc_exp_cnt = 2'd3;
          end
        end else if (sc_exp_cnt == 2'd3 ||
                     (sc_exp_cnt == 2'd2 && sc_exp_val >= sc_limit)) begin
          sc_phase = P_BAD;
        end else begin
          close_trail(s);
        end
      end
      P_TRAIL: close_trail(s);
      default: sc_phase = sc_phase;
    endcase
  endtask

  task automatic predict_word(input logic [7:0] ch, input logic eos);
    if (eos) begin
      scan_symbol(SYM_END);
      verdicts_due.push_back(sc_phase == P_DONE);
      clear_scan();
    end else begin
      scan_symbol({1'b0, ch});
    end
  endtask

  // Valid stays high after a handshake until the next call inserts a gap or presents a new word, or a drain lowers it.
  task automatic send_word(input logic [7:0] ch, input logic eos);
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    predict_word(ch, eos);
    if (eos) strings_sent++;
    else chars_sent++;
  endtask

  task automatic send_candidate();
    foreach (cand[i]) begin
      send_word(cand[i], 1'b0);
    end
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    cand.delete();
    for (int i = 0; i < s.len(); i++) begin
      cand.push_back(s[i]);
    end
    send_candidate();
  endtask

  task automatic send_digits(input int count);
    cand.delete();
    repeat (count) cand.push_back(CHR_ZERO + 8'($urandom_range(9)));
    send_candidate();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sc_limit = value;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0: return CHR_SPACE;
      1: return CHR_TAB;
      default: return CHR_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_any();
    case ($urandom_range(7))
      0: return CHR_ZERO + 8'($urandom_range(9));
      1: return pick_blank();
      2: return $urandom_range(1) ? CHR_PLUS : CHR_MINUS;
      3: return CHR_POINT;
      4: return $urandom_range(1) ? CHR_E_LO : CHR_E_UP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed literals with random content, some noise and damage.
  task automatic make_candidate();
    int n;
    int r;
    cand.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(6)) cand.push_back(pick_any());
    end else begin
      repeat ($urandom_range(2)) cand.push_back(pick_blank());
      if ($urandom_range(2) == 0) cand.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
      r = $urandom_range(99);
      if (r < 10) n = 0;
      else if (r < 88) n = $urandom_range(1, 4);
      else n = int'(sc_limit) - 1 + $urandom_range(2);
      if (n < 0) n = 0;
      repeat (n) cand.push_back(CHR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(99) < 40) begin
        cand.push_back(CHR_POINT);
        repeat ($urandom_range(3)) cand.push_back(CHR_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(99) < 45) begin
        cand.push_back($urandom_range(1) ? CHR_E_LO : CHR_E_UP);
        if ($urandom_range(1)) cand.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
        r = $urandom_range(9);
        n = (r < 4) ? 1 : (r < 8) ? 2 : (r == 8) ? 0 : 3;
        repeat (n) cand.push_back(CHR_ZERO + 8'($urandom_range(9)));
      end
      repeat ($urandom_range(2)) cand.push_back(pick_blank());
      if ($urandom_range(99) < 15 && cand.size() > 0) begin
        cand[$urandom_range(cand.size() - 1)] = pick_any();
      end
    end
  endtask

  task automatic test_blank_strings();
    send_text("");
    send_text(" \t\n");
    cand.delete();
    cand.push_back(CHR_NUL);
    send_candidate();
    send_text("\t42\n");
    send_text("4 2");
  endtask

  task automatic test_mantissa_forms();
    send_text("+7");
    send_text("-.5");
    send_text("5.");
    send_text(".");
    send_text("+");
    send_text("1.2.3");
  endtask

  task automatic test_exponent_forms();
    send_text("1e37");
    send_text("1E38");
    send_text("1e+5 ");
    send_text("1e-99");
    send_text("1e100");
    send_text("2e");
    send_text("3e-");
  endtask

  task automatic test_integer_limits();
    drain_results();
    write_limit(6'd3);
    send_text("12");
    send_text("123");
    drain_results();
    write_limit(6'd63);
    send_digits(62);
    send_digits(63);
    send_digits(70);
    send_text("1e62");
    send_text("1e63");
    drain_results();
    write_limit(6'd0);
    send_text("1");
    send_text(".5");
    drain_results();
    write_limit(6'd1);
    send_text("0.5e0");
    send_text("7e10");
  endtask

  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int seg_chars);
    int goal;
    logic [LIMIT_W-1:0] plan [3];
    plan[0] = LIMIT_RESET;
    plan[1] = $urandom_range(1) ? 6'd1 : 6'd63;
    plan[2] = 6'($urandom_range(2, 62));
    src_gap_pct = src_pct;
    sink_stall_pct = sink_pct;
    foreach (plan[k]) begin
      drain_results();
      write_limit(plan[k]);
      goal = chars_sent + seg_chars;
      while (chars_sent < goal) begin
        make_candidate();
        send_candidate();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    clear_scan();
    sc_limit = LIMIT_RESET;
    test_blank_strings();
    test_mantissa_forms();
    test_exponent_forms();
    test_integer_limits();
    test_random_traffic(9, 46, 20);
    test_random_traffic(46, 9, 20);
    test_random_traffic(0, 0, 20);
    drain_results();
    $display("Sent %0d characters in %0d strings; %0d verdicts checked, %0d valid.",
             chars_sent, strings_sent, verdicts_seen, valid_seen);
    $display("Limits 0, 1, 3, 38, 63 and random, under three stall mixes.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
